// ----- rtl/blc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package blc_pkg;

   localparam int TIME_WIDTH    = 24;
   localparam int ELAPSED_WIDTH = 16;
   localparam int CYCLE_WIDTH   = 24;
   localparam int CSR_WIDTH     = 24;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int LEVEL_WIDTH   = 16;
   localparam int SHAPED_WIDTH  = 17;
   localparam int EXP_WIDTH     = 8;
   localparam int CHAN_WIDTH    = 8;

   localparam logic [SHAPED_WIDTH-1:0] LEVEL_ONE = 17'h10000;
   localparam logic [9:0] MS_PER_SECOND = 10'd1000;

   localparam longint unsigned Q30_ONE     = 64'd1 << 30;
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_CYCLE_LENGTH = 3'd0,
      CSR_MASTER_LEVEL = 3'd1,
      CSR_SPEED        = 3'd2,
      CSR_SHAPE_EXP    = 3'd3,
      CSR_BASE_RED     = 3'd4,
      CSR_BASE_GREEN   = 3'd5,
      CSR_BASE_BLUE    = 3'd6
   } csr_index_type;

   localparam logic [CYCLE_WIDTH-1:0] CYCLE_RESET  = 24'd1000;
   localparam logic [7:0]             MASTER_RESET = 8'd255;
   localparam logic [7:0]             SPEED_RESET  = 8'd1;
   localparam logic [EXP_WIDTH-1:0]   EXP_RESET    = 8'd1;
   localparam logic [CHAN_WIDTH-1:0]  BASE_RESET   = 8'd255;

endpackage

`default_nettype wire

// ----- rtl/breathing_led_color.sv -----
// Throughput: one transaction per cycle; the whole pipeline holds while the response is stalled.
// Timing is set by the bit-serial remainder (24 stages) and phase (FRACTION_BITS stages) dividers
// and the eight square-and-multiply stages of the shaping power.
// Reset clears all stage valid bits and loads the register defaults; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module breathing_led_color #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int FRACTION_BITS    = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [5:0]                           req_seconds,
   input  wire logic [9:0]                           req_milliseconds,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [blc_pkg::CHAN_WIDTH-1:0]            rsp_out_red,
   output logic [blc_pkg::CHAN_WIDTH-1:0]            rsp_out_green,
   output logic [blc_pkg::CHAN_WIDTH-1:0]            rsp_out_blue,
   input  wire logic                                 csr_write_enable,
   input  wire logic [blc_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  wire logic [blc_pkg::CSR_WIDTH-1:0]        csr_write_data
);

   localparam int TW      = blc_pkg::TIME_WIDTH;
   localparam int CW      = blc_pkg::CYCLE_WIDTH;
   localparam int FB      = FRACTION_BITS;
   localparam int IW      = $clog2(SINE_TABLE_DEPTH);
   localparam int PW      = FB + IW + 1;
   localparam int LW      = blc_pkg::LEVEL_WIDTH;
   localparam int SW      = blc_pkg::SHAPED_WIDTH;
   localparam int EW      = blc_pkg::EXP_WIDTH;
   localparam int S_ELAP  = 0;
   localparam int S_T     = 1;
   localparam int S_REM0  = S_T + 1;
   localparam int S_PH0   = S_REM0 + TW;
   localparam int S_IDX   = S_PH0 + FB;
   localparam int S_ROM   = S_IDX + 1;
   localparam int S_POW0  = S_ROM + 1;
   localparam int S_P1    = S_POW0 + EW;
   localparam int S_P2    = S_P1 + 1;
   localparam int S_OUT   = S_P2 + 1;
   localparam int NSTAGE  = S_OUT + 1;

   // ---------------- configuration registers ----------------
   logic [CW-1:0]                   cycle_ff;
   logic [7:0]                      master_ff;
   logic [7:0]                      speed_ff;
   logic [EW-1:0]                   exp_ff;
   logic [blc_pkg::CHAN_WIDTH-1:0]  base_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ff  <= blc_pkg::CYCLE_RESET;
         master_ff <= blc_pkg::MASTER_RESET;
         speed_ff  <= blc_pkg::SPEED_RESET;
         exp_ff    <= blc_pkg::EXP_RESET;
         base_ff[0] <= blc_pkg::BASE_RESET;
         base_ff[1] <= blc_pkg::BASE_RESET;
         base_ff[2] <= blc_pkg::BASE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            blc_pkg::CSR_CYCLE_LENGTH: cycle_ff   <= csr_write_data[CW-1:0];
            blc_pkg::CSR_MASTER_LEVEL: master_ff  <= csr_write_data[7:0];
            blc_pkg::CSR_SPEED:        speed_ff   <= csr_write_data[7:0];
            blc_pkg::CSR_SHAPE_EXP:    exp_ff     <= csr_write_data[EW-1:0];
            blc_pkg::CSR_BASE_RED:     base_ff[0] <= csr_write_data[7:0];
            blc_pkg::CSR_BASE_GREEN:   base_ff[1] <= csr_write_data[7:0];
            blc_pkg::CSR_BASE_BLUE:    base_ff[2] <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // zero period acts as one
   logic [CW-1:0] cyc;
   assign cyc = (cycle_ff == '0) ? CW'(1) : cycle_ff;

   // ---------------- pipeline control ----------------
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;
   logic              adv;

   assign adv       = !vld_ff[NSTAGE-1] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NSTAGE-1];
   assign vld_in    = {vld_ff[NSTAGE-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- elapsed time and scaled time ----------------
   logic [blc_pkg::ELAPSED_WIDTH-1:0] elapsed_ff;
   logic [TW-1:0]                     t_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         elapsed_ff <= blc_pkg::ELAPSED_WIDTH'(req_seconds)
                       * blc_pkg::ELAPSED_WIDTH'(blc_pkg::MS_PER_SECOND)
                       + blc_pkg::ELAPSED_WIDTH'(req_milliseconds);
         t_ff       <= TW'(elapsed_ff) * TW'(speed_ff);
      end
   end

   // ---------------- remainder: one bit per stage ----------------
   logic [CW-1:0] rem_ff [TW];
   logic [TW-1:0] tq_ff  [TW];

   for (genvar k = 0; k < TW; k++) begin : g_rem
      logic [CW-1:0] rem_src;
      logic [TW-1:0] t_src;
      logic [CW:0]   trial;
      logic [CW-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_src = '0;
         assign t_src   = t_ff;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign t_src   = tq_ff[k-1];
      end

      assign trial  = {rem_src, t_src[TW-1-k]};
      assign rem_in = (trial >= {1'b0, cyc}) ? CW'(trial - {1'b0, cyc}) : trial[CW-1:0];

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            tq_ff[k]  <= t_src;
         end
      end
   end

   // ---------------- phase = (rem << FB) / cycle, one bit per stage ----------------
   logic [CW-1:0] pr_ff [FB];
   logic [FB-1:0] q_ff  [FB];

   for (genvar j = 0; j < FB; j++) begin : g_phase
      logic [CW-1:0] r_src;
      logic [FB-1:0] q_src;
      logic [CW:0]   trial;
      logic          qbit;

      if (j == 0) begin : g_first
         assign r_src = rem_ff[TW-1];
         assign q_src = '0;
      end else begin : g_next
         assign r_src = pr_ff[j-1];
         assign q_src = q_ff[j-1];
      end

      assign trial = {r_src, 1'b0};
      assign qbit  = (trial >= {1'b0, cyc});

      always_ff @(posedge clock) begin
         if (adv) begin
            pr_ff[j] <= qbit ? CW'(trial - {1'b0, cyc}) : trial[CW-1:0];
            q_ff[j]  <= {q_src[FB-2:0], qbit};
         end
      end
   end

   // ---------------- table index ----------------
   logic [PW-1:0] idx_wide;
   logic [IW-1:0] idx_ff;

   assign idx_wide = (PW'(q_ff[FB-1]) * PW'(SINE_TABLE_DEPTH)) >> FB;

   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff <= (idx_wide >= PW'(SINE_TABLE_DEPTH)) ? IW'(SINE_TABLE_DEPTH - 1)
                                                       : idx_wide[IW-1:0];
      end
   end

   // ---------------- breathing level table ----------------
   function automatic logic [LW-1:0] level_entry(input int unsigned i);
      longint unsigned u;
      longint unsigned q;
      longint unsigned f;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned v;
      u = (64'(i) << 32) / SINE_TABLE_DEPTH;
      q = (u >> 30) & 64'd3;
      f = u & (blc_pkg::Q30_ONE - 64'd1);
      if (q[0]) f = blc_pkg::Q30_ONE - f;
      x    = (f * blc_pkg::PI_HALF_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      if (sum > blc_pkg::Q30_ONE) sum = blc_pkg::Q30_ONE;
      v = (q >= 64'd2) ? (blc_pkg::Q30_ONE - sum) : (blc_pkg::Q30_ONE + sum);
      v = (v + (64'd1 << 14)) >> 15;
      if (v > 64'd65535) v = 64'd65535;
      return v[LW-1:0];
   endfunction

   logic [LW-1:0] level_rom [SINE_TABLE_DEPTH];

   for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
      assign level_rom[i] = level_entry(i);
   end

   logic [LW-1:0] level_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         level_ff <= level_rom[idx_ff];
      end
   end

   // ---------------- shaping power: one exponent bit per stage ----------------
   logic [SW-1:0] r_ff [EW];
   logic [LW-1:0] b_ff [EW];

   for (genvar p = 0; p < EW; p++) begin : g_pow
      logic [SW-1:0]   r_src;
      logic [LW-1:0]   b_src;
      logic [SW+LW-1:0] rb;
      logic [2*LW-1:0] bb;

      if (p == 0) begin : g_first
         assign r_src = blc_pkg::LEVEL_ONE;
         assign b_src = level_ff;
      end else begin : g_next
         assign r_src = r_ff[p-1];
         assign b_src = b_ff[p-1];
      end

      assign rb = r_src * b_src;
      assign bb = b_src * b_src;

      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[p] <= exp_ff[p] ? rb[SW+LW-1:LW] : r_src;
            b_ff[p] <= bb[2*LW-1:LW];
         end
      end
   end

   // ---------------- channel scaling ----------------
   localparam int P1W = blc_pkg::CHAN_WIDTH + SW;
   localparam int P2W = P1W + 8;

   logic [P1W-1:0] p1_ff [3];
   logic [P2W-1:0] p2_ff [3];
   logic [blc_pkg::CHAN_WIDTH-1:0] out_ff [3];

   for (genvar c = 0; c < 3; c++) begin : g_chan
      logic [P2W-17:0] w;
      logic [P2W-16:0] div_sum;

      // divide by 255: (w + w/256 + 1) / 256 is exact in this range
      assign w       = p2_ff[c][P2W-1:16];
      assign div_sum = {1'b0, w} + (P2W-15)'(w >> 8) + (P2W-15)'(1);

      always_ff @(posedge clock) begin
         if (adv) begin
            p1_ff[c]  <= base_ff[c] * r_ff[EW-1];
            p2_ff[c]  <= p1_ff[c] * master_ff;
            out_ff[c] <= div_sum[15:8];
         end
      end
   end

   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];

   // ---------------- assertions ----------------
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[S_ELAP])
      else $error("accepted transaction did not enter the pipeline");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NSTAGE-1] && rsp_stall) |=> $stable(vld_ff))
      else $error("pipeline moved while the response was stalled");

   a_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_PH0-1] |-> (rem_ff[TW-1] < cyc))
      else $error("remainder not below the period");

   a_phase: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_IDX-1] |-> (pr_ff[FB-1] < cyc))
      else $error("phase divider residue not below the period");

   a_shape: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[S_P1-1] && exp_ff == '0) |-> (r_ff[EW-1] == blc_pkg::LEVEL_ONE))
      else $error("zero exponent did not give full level");

endmodule

`default_nettype wire

// ----- test/breathing_led_color_tb.sv -----
`timescale 1ns / 1ps

module breathing_led_color_tb;

   localparam int IDXW = blc_pkg::CSR_IDX_WIDTH;
   localparam int DW = blc_pkg::CSR_WIDTH;
   localparam int LATENCY = 39 + 16;
   localparam int TABLE_DEPTH = 1024;
   localparam int HOLD_CYCLES = 300;
   localparam logic [IDXW-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   typedef struct {
      bit              is_csr;
      logic [IDXW-1:0] idx;
      logic [DW-1:0]   data;
      logic [5:0]      sec;
      logic [9:0]      ms;
      bit              known;
      color_type       color;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [5:0] req_seconds = 0;
   logic [9:0] req_milliseconds = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [blc_pkg::CHAN_WIDTH-1:0] rsp_out_red, rsp_out_green, rsp_out_blue;
   logic csr_write_enable = 0;
   logic [IDXW-1:0] csr_index = 0;
   logic [DW-1:0] csr_write_data = 0;

   breathing_led_color DUT (.*);

   // shadow copy of the color registers
   logic [23:0] cycle_len;
   logic [7:0]  master, speed, shape;
   logic [7:0]  base_r, base_g, base_b;

   color_type colors_due[$];
   int     mismatches = 0;
   int     send_idle_pct = 0;
   int     stall_pct = 0;
   logic   hold_go = 0;
   bit     hold_done = 0;
   int     hold_left = 0;

   stim_row_type directed[27] = '{
      '{0, 0, 0, 0, 0, 1, '{8'd127, 8'd127, 8'd127}},
      '{0, 0, 0, 0, 250, 1, '{8'd254, 8'd254, 8'd254}},
      '{0, 0, 0, 63, 1023, 0, '0},
      '{0, 0, 0, 59, 999, 0, '0},
      '{0, 0, 0, 0, 500, 0, '0},
      '{0, 0, 0, 0, 750, 0, '0},
      '{1, blc_pkg::CSR_CYCLE_LENGTH, 0, 0, 0, 0, '0},
      '{0, 0, 0, 12, 345, 0, '0},
      '{1, blc_pkg::CSR_CYCLE_LENGTH, 24'hFFFFFF, 0, 0, 0, '0},
      '{0, 0, 0, 63, 1023, 0, '0},
      '{1, blc_pkg::CSR_SPEED, 255, 0, 0, 0, '0},
      '{0, 0, 0, 63, 1023, 0, '0},
      '{1, blc_pkg::CSR_CYCLE_LENGTH, 1000, 0, 0, 0, '0},
      '{1, blc_pkg::CSR_SPEED, 1, 0, 0, 0, '0},
      '{1, blc_pkg::CSR_SHAPE_EXP, 0, 0, 0, 0, '0},
      '{0, 0, 0, 0, 750, 1, '{8'd255, 8'd255, 8'd255}},
      '{1, blc_pkg::CSR_MASTER_LEVEL, 0, 0, 0, 0, '0},
      '{0, 0, 0, 0, 250, 1, '{8'd0, 8'd0, 8'd0}},
      '{1, CSR_UNUSED, 24'hFFFFFF, 0, 0, 0, '0},
      '{0, 0, 0, 0, 250, 1, '{8'd0, 8'd0, 8'd0}},
      '{1, blc_pkg::CSR_MASTER_LEVEL, 255, 0, 0, 0, '0},
      '{1, blc_pkg::CSR_SHAPE_EXP, 255, 0, 0, 0, '0},
      '{0, 0, 0, 0, 250, 0, '0},
      '{1, blc_pkg::CSR_BASE_RED, 0, 0, 0, 0, '0},
      '{1, blc_pkg::CSR_BASE_GREEN, 128, 0, 0, 0, '0},
      '{1, blc_pkg::CSR_BASE_BLUE, 1, 0, 0, 0, '0},
      '{0, 0, 0, 0, 250, 0, '0}
   };

   function automatic longint unsigned breathing_level(longint unsigned idx);
      longint unsigned u, q, f, x, x2, term, s, v;
      u = (idx << 32) / TABLE_DEPTH;
      q = (u >> 30) & 3;
      f = u & (blc_pkg::Q30_ONE - 1);
      if (q & 1) f = blc_pkg::Q30_ONE - f;
      x = (f * blc_pkg::PI_HALF_Q30) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      s = x;
      for (int k = 1; k <= 5; k++) begin
         term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
         if (k & 1) s = s - term;
         else s = s + term;
      end
      if (s > blc_pkg::Q30_ONE) s = blc_pkg::Q30_ONE;
      v = (q >= 2) ? blc_pkg::Q30_ONE - s : blc_pkg::Q30_ONE + s;
      v = (v + (64'd1 << 14)) >> 15;
      if (v > 65535) v = 65535;
      return v;
   endfunction

   function automatic color_type breathing_color(logic [5:0] sec, logic [9:0] ms);
      longint unsigned cyc, t, phase, idx, r, b;
      logic [7:0] e;
      color_type c;
      cyc = (cycle_len == 0) ? 1 : cycle_len;
      t = (sec * 64'd1000 + ms) * speed;
      phase = ((t % cyc) << 16) / cyc;
      idx = (phase * TABLE_DEPTH) >> 16;
      if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
      r = 65536;
      b = breathing_level(idx);
      e = shape;
      while (e != 0) begin
         if (e[0]) r = (r * b) >> 16;
         b = (b * b) >> 16;
         e = e >> 1;
      end
      c.red   = (base_r * r * master) / (255 * 64'd65536);
      c.green = (base_g * r * master) / (255 * 64'd65536);
      c.blue  = (base_b * r * master) / (255 * 64'd65536);
      return c;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

   // response checker and receiver back-pressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (colors_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction %0d/%0d/%0d",
                                              rsp_out_red, rsp_out_green, rsp_out_blue);
            end else begin
               color_type want;
               want = colors_due.pop_front();
               if (want.red !== rsp_out_red || want.green !== rsp_out_green ||
                   want.blue !== rsp_out_blue) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("color mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                              want.red, want.green, want.blue,
                              rsp_out_red, rsp_out_green, rsp_out_blue);
               end
            end
         end
         if (hold_go && !hold_done) begin
            hold_done <= 1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic csr_write(logic [IDXW-1:0] idx, logic [DW-1:0] data);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         blc_pkg::CSR_CYCLE_LENGTH: cycle_len = data;
         blc_pkg::CSR_MASTER_LEVEL: master = data[7:0];
         blc_pkg::CSR_SPEED:        speed = data[7:0];
         blc_pkg::CSR_SHAPE_EXP:    shape = data[7:0];
         blc_pkg::CSR_BASE_RED:     base_r = data[7:0];
         blc_pkg::CSR_BASE_GREEN:   base_g = data[7:0];
         blc_pkg::CSR_BASE_BLUE:    base_b = data[7:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 0;
      while (colors_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic send_stamp(logic [5:0] sec, logic [9:0] ms, bit known, color_type typed);
      req_valid <= 1;
      req_seconds <= sec;
      req_milliseconds <= ms;
      do @(posedge clock); while (req_stall);
      colors_due.push_back(known ? typed : breathing_color(sec, ms));
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   initial begin
      logic [DW-1:0] value;
      cycle_len = blc_pkg::CYCLE_RESET;
      master = blc_pkg::MASTER_RESET;
      speed = blc_pkg::SPEED_RESET;
      shape = blc_pkg::EXP_RESET;
      base_r = blc_pkg::BASE_RESET;
      base_g = blc_pkg::BASE_RESET;
      base_b = blc_pkg::BASE_RESET;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            drain();
            csr_write(directed[i].idx, directed[i].data);
            csr_write_enable <= 0;
         end else begin
            send_stamp(directed[i].sec, directed[i].ms, directed[i].known, directed[i].color);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < 245; n++) begin
            if (n % 61 == 0) begin
               drain();
               send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 55 : 0;
               stall_pct     = (phase == 0) ? 55 : (phase == 1) ? 38 : 0;
               for (int r = blc_pkg::CSR_CYCLE_LENGTH; r <= blc_pkg::CSR_BASE_BLUE; r++) begin
                  case ($urandom_range(4))
                     0: value = '0;
                     1: value = (r == blc_pkg::CSR_CYCLE_LENGTH) ? 24'hFFFFFF : 24'hFF;
                     2: value = (r == blc_pkg::CSR_CYCLE_LENGTH) ? DW'($urandom_range(5000, 1))
                                                                 : DW'($urandom_range(8, 1));
                     default: value = (r == blc_pkg::CSR_CYCLE_LENGTH)
                                      ? DW'($urandom_range(24'hFFFFFF))
                                      : DW'($urandom_range(255));
                  endcase
                  csr_write(IDXW'(r), value);
               end
               csr_write_enable <= 0;
            end
            // stall the receiver long enough to back the pipeline up into the input
            if (phase == 2 && n == 1) hold_go <= 1;
            send_stamp(6'($urandom_range(63)), 10'($urandom_range(1023)), 0, '0);
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/blc_pkg.sv
rtl/breathing_led_color.sv
test/breathing_led_color_tb.sv
